// ===== rtl/core/hc37_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc37_pkg
// Shared types, constants and symbol helpers for the mod-37 Hill cipher core.
// ----------------------------------------------------------------------------
package hc37_pkg;

	localparam int MAX_BLOCK   = 7;
	localparam int SYM_W       = 6;
	localparam int CHAR_W      = 8;
	localparam int CNT_W       = 3;
	localparam int KEY_W       = SYM_W * MAX_BLOCK;
	localparam int PROD_W      = 2 * SYM_W;
	localparam int SUM_W       = 15;
	localparam int APB_DATA_W  = 64;
	localparam int APB_ADDR_W  = 6;
	localparam int REG_IDX_LSB = 3;

	localparam int MOD_SYM     = 37;
	localparam int SYM_SPACE   = 36;
	localparam int NUM_LETTERS = 26;
	localparam int CHAR_A      = 65;
	localparam int CHAR_Z      = 90;
	localparam int CHAR_0      = 48;
	localparam int CHAR_9      = 57;
	localparam int CHAR_SP     = 32;

	// Reciprocal of 37 scaled by 2^19 and rounded up; exact for all sums in range.
	localparam int RECIP       = 14170;
	localparam int RECIP_SHIFT = 19;
	localparam int RECIP_W     = 14;
	localparam int MUL_W       = SUM_W + RECIP_W;
	localparam int QUOT_W      = MUL_W - RECIP_SHIFT;

	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [KEY_W-1:0]  key_row_t;
	typedef logic [SUM_W-1:0]  sum_t;

	typedef enum logic [CNT_W-1:0] {
		REG_BLOCK_SIZE = 3'd0,
		REG_KEY_ROW_0  = 3'd1,
		REG_KEY_ROW_1  = 3'd2,
		REG_KEY_ROW_2  = 3'd3,
		REG_KEY_ROW_3  = 3'd4,
		REG_KEY_ROW_4  = 3'd5,
		REG_KEY_ROW_5  = 3'd6,
		REG_KEY_ROW_6  = 3'd7
	} reg_idx_t;

	localparam logic [CNT_W-1:0] BLOCK_SIZE_RST = 3'd2;

	function automatic sym_t char_to_sym(input char_t ch);
		sym_t s;
		if (ch >= CHAR_W'(CHAR_A) && ch <= CHAR_W'(CHAR_Z)) begin
			s = SYM_W'(ch - CHAR_W'(CHAR_A));
		end else if (ch >= CHAR_W'(CHAR_0) && ch <= CHAR_W'(CHAR_9)) begin
			s = SYM_W'(ch - CHAR_W'(CHAR_0) + CHAR_W'(NUM_LETTERS));
		end else begin
			s = SYM_W'(SYM_SPACE);
		end
		return s;
	endfunction

	function automatic char_t sym_to_char(input sym_t s);
		char_t c;
		if (s < SYM_W'(NUM_LETTERS)) begin
			c = CHAR_W'(s) + CHAR_W'(CHAR_A);
		end else if (s < SYM_W'(SYM_SPACE)) begin
			c = CHAR_W'(s) - CHAR_W'(NUM_LETTERS) + CHAR_W'(CHAR_0);
		end else begin
			c = CHAR_W'(CHAR_SP);
		end
		return c;
	endfunction

	// Remainder by 37 through a reciprocal multiply; the quotient estimate is exact.
	function automatic sym_t mod_sym(input sum_t s);
		logic [MUL_W-1:0]  prod;
		logic [QUOT_W-1:0] quot;
		sum_t              rem;
		prod = MUL_W'(s) * MUL_W'(RECIP);
		quot = prod[MUL_W-1:RECIP_SHIFT];
		rem  = s - SUM_W'(quot) * SUM_W'(MOD_SYM);
		return rem[SYM_W-1:0];
	endfunction

endpackage

// ===== rtl/core/hc37_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc37 stream interfaces
// Valid/ready channels for plaintext items in and ciphertext items out.
// ----------------------------------------------------------------------------
interface hc37_in_if;
	logic                  valid;
	logic                  ready;
	hc37_pkg::char_t       plain_char;
	logic                  message_end;

	modport source (output valid, output plain_char, output message_end, input ready);
	modport sink   (input valid, input plain_char, input message_end, output ready);
endinterface

interface hc37_out_if;
	logic                  valid;
	logic                  ready;
	hc37_pkg::char_t       cipher_char;
	logic                  block_last;

	modport source (output valid, output cipher_char, output block_last, input ready);
	modport sink   (input valid, input cipher_char, input block_last, output ready);
endinterface

// ===== rtl/core/hill_cipher_mod37_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_mod37_encoder_core
// Hill cipher encoder over A-Z, 0-9 and space with a key of up to 7x7.
// ----------------------------------------------------------------------------
// Usage:
// Plaintext characters enter on in_ch, one item per accepted valid/ready
// handshake. Symbols collect in a buffer until block_size of them are held,
// or until an item flagged message_end arrives, which pads with spaces.
// A finished block moves into a holding register and then into the row
// engine, which produces one ciphertext row per cycle unless out_ch stalls,
// through a multiply-accumulate stage (_s1) and the mod-37 reduction into
// the output register. Throughput: one input item per cycle while out_ch
// is ready, limited only by the row engine emitting block_size items per
// block; with block_size of 1 the holding register still allows one item
// per cycle. If out_ch stalls, the pipeline holds; in_ch keeps accepting
// until a finished block has to wait behind a block that is still being
// emitted. Reset clears the buffer fill, all valids, sets block_size to 2
// and the key to zero. Configuration uses the APB port (64-bit data,
// register i at 8*i) and is to be written by the user only while no block
// is in flight; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module hill_cipher_mod37_encoder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [hc37_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [hc37_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [hc37_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	hc37_in_if.sink                             in_ch,
	hc37_out_if.source                          out_ch
);

	// Configuration registers
	hc37_pkg::cnt_t     bsize_q;
	hc37_pkg::key_row_t key_q [hc37_pkg::MAX_BLOCK];
	hc37_pkg::reg_idx_t reg_idx;
	logic               cfg_wr;

	// Collection buffer
	hc37_pkg::sym_t     buf_q  [hc37_pkg::MAX_BLOCK];
	hc37_pkg::sym_t     buf_nx [hc37_pkg::MAX_BLOCK];
	hc37_pkg::sym_t     blk    [hc37_pkg::MAX_BLOCK];
	hc37_pkg::cnt_t     fill_q;
	hc37_pkg::cnt_t     fill_nx;
	hc37_pkg::cnt_t     n_act;
	hc37_pkg::sym_t     in_sym;
	logic               in_acc;
	logic               blk_done;

	// Holding register for a finished block
	logic               pend_q;
	hc37_pkg::sym_t     pvec_q [hc37_pkg::MAX_BLOCK];
	hc37_pkg::cnt_t     pn_q;
	logic               pend_take;

	// Row engine
	logic               ebusy_q;
	hc37_pkg::sym_t     evec_q [hc37_pkg::MAX_BLOCK];
	hc37_pkg::cnt_t     en_q;
	hc37_pkg::cnt_t     erow_q;
	logic               row_last;
	logic               issue;
	hc37_pkg::sum_t     row_sum;
	hc37_pkg::key_row_t row_key;

	// Pipeline and output register
	logic               v_s1;
	hc37_pkg::sum_t     sum_s1;
	logic               last_s1;
	logic               o_v_q;
	hc37_pkg::char_t    o_char_q;
	logic               o_last_q;
	logic               o_load;
	logic               s1_adv;

	// ------------------------------------------------------------------
	// APB configuration port
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = hc37_pkg::reg_idx_t'(paddr[hc37_pkg::APB_ADDR_W-1:hc37_pkg::REG_IDX_LSB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q <= hc37_pkg::BLOCK_SIZE_RST;
			for (int r = 0; r < hc37_pkg::MAX_BLOCK; r++) begin
				key_q[r] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (reg_idx)
				hc37_pkg::REG_BLOCK_SIZE: begin
					bsize_q <= pwdata[hc37_pkg::CNT_W-1:0];
				end
				default: begin
					key_q[reg_idx - hc37_pkg::REG_KEY_ROW_0] <= pwdata[hc37_pkg::KEY_W-1:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			hc37_pkg::REG_BLOCK_SIZE: begin
				prdata = hc37_pkg::APB_DATA_W'(bsize_q);
			end
			default: begin
				prdata = hc37_pkg::APB_DATA_W'(key_q[reg_idx - hc37_pkg::REG_KEY_ROW_0]);
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Symbol collection
	// ------------------------------------------------------------------
	assign n_act  = (bsize_q == '0) ? hc37_pkg::CNT_W'(1) : bsize_q;
	assign in_sym = hc37_pkg::char_to_sym(in_ch.plain_char);
	assign in_acc = in_ch.valid & in_ch.ready;

	always_comb begin
		fill_nx  = (fill_q < hc37_pkg::CNT_W'(hc37_pkg::MAX_BLOCK)) ?
			fill_q + hc37_pkg::CNT_W'(1) : fill_q;
		blk_done = (fill_nx >= n_act) || in_ch.message_end;
		// A full buffer drops the symbol; entries past the fill but inside the block size are padded with space.
		for (int j = 0; j < hc37_pkg::MAX_BLOCK; j++) begin
			buf_nx[j] = (hc37_pkg::CNT_W'(j) == fill_q) ? in_sym : buf_q[j];
			if (hc37_pkg::CNT_W'(j) >= n_act) begin
				blk[j] = '0;
			end else if (hc37_pkg::CNT_W'(j) < fill_nx) begin
				blk[j] = buf_nx[j];
			end else begin
				blk[j] = hc37_pkg::SYM_W'(hc37_pkg::SYM_SPACE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int j = 0; j < hc37_pkg::MAX_BLOCK; j++) begin
				buf_q[j] <= buf_nx[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_acc) begin
			fill_q <= blk_done ? '0 : fill_nx;
		end
	end

	// ------------------------------------------------------------------
	// Handoff of finished blocks
	// ------------------------------------------------------------------
	assign o_load    = !o_v_q || out_ch.ready;
	assign s1_adv    = !v_s1 || o_load;
	assign issue     = ebusy_q && s1_adv;
	assign row_last  = (erow_q == en_q - hc37_pkg::CNT_W'(1));
	assign pend_take = pend_q && (!ebusy_q || (issue && row_last));
	assign in_ch.ready = !pend_q || pend_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			pn_q   <= '0;
		end else if (in_acc && blk_done) begin
			pend_q <= 1'b1;
			pn_q   <= n_act;
		end else if (pend_take) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && blk_done) begin
			for (int j = 0; j < hc37_pkg::MAX_BLOCK; j++) begin
				pvec_q[j] <= blk[j];
			end
		end
	end

	// ------------------------------------------------------------------
	// Row engine: one key row against the block vector per cycle unless out_ch stalls
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ebusy_q <= 1'b0;
			en_q    <= '0;
			erow_q  <= '0;
		end else if (pend_take) begin
			ebusy_q <= 1'b1;
			en_q    <= pn_q;
			erow_q  <= '0;
		end else if (issue) begin
			erow_q <= erow_q + hc37_pkg::CNT_W'(1);
			if (row_last) begin
				ebusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_take) begin
			for (int j = 0; j < hc37_pkg::MAX_BLOCK; j++) begin
				evec_q[j] <= pvec_q[j];
			end
		end
	end

	// Lanes past the block size hold zero, so they add nothing to the sum.
	always_comb begin
		row_key = key_q[erow_q];
		row_sum = '0;
		for (int j = 0; j < hc37_pkg::MAX_BLOCK; j++) begin
			row_sum = row_sum + hc37_pkg::SUM_W'(
				hc37_pkg::PROD_W'(row_key[j*hc37_pkg::SYM_W +: hc37_pkg::SYM_W]) *
				hc37_pkg::PROD_W'(evec_q[j]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (issue) begin
			v_s1 <= 1'b1;
		end else if (o_load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sum_s1  <= row_sum;
			last_s1 <= row_last;
		end
	end

	// ------------------------------------------------------------------
	// Reduction and output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
		end else if (o_load) begin
			o_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (o_load && v_s1) begin
			o_char_q <= hc37_pkg::sym_to_char(hc37_pkg::mod_sym(sum_s1));
			o_last_q <= last_s1;
		end
	end

	assign out_ch.valid       = o_v_q;
	assign out_ch.cipher_char = o_char_q;
	assign out_ch.block_last  = o_last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ebusy_q |-> (erow_q < en_q))
		else $error("row engine index ran past the block size");

	a_engine_size: assert property (@(posedge clk) disable iff (!arst_n)
		ebusy_q |-> (en_q != '0))
		else $error("row engine busy with an empty block");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && o_v_q && !out_ch.ready) |=> (v_s1 && $stable(sum_s1)))
		else $error("accumulate stage changed while the output stalled");

endmodule

// ===== bench/hill_cipher_mod37_encoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_mod37_encoder_core_tb
// Self-checking bench for the mod-37 Hill cipher encoder core.
// A clocked driver sends plaintext items from a queue in random bursts, and a
// clocked monitor stalls the ciphertext channel on its own pattern. The
// monitor checks every item against a Hill cipher calculation kept in the
// bench. The APB port steps through block sizes and keys between phases.
// ----------------------------------------------------------------------------
module hill_cipher_mod37_encoder_core_tb;
	import hc37_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 4;
	localparam int DRAIN_CYCLES  = 12;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 44;

	typedef struct {
		char_t ch;
		logic  last;
		logic  drain;
	} plain_item_t;

	typedef struct packed {
		char_t ch;
		logic  last;
	} cipher_item_t;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	hc37_in_if  plain_if ();
	hc37_out_if cipher_if ();

	hill_cipher_mod37_encoder_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (plain_if),
		.out_ch  (cipher_if)
	);

	// Cipher state as the bench sees it.
	cnt_t     size_reg;
	key_row_t key_rows [MAX_BLOCK];
	sym_t     sym_buf  [MAX_BLOCK];
	int       fill;

	plain_item_t  plain_queue [$];
	cipher_item_t cipher_expected [$];
	plain_item_t  next_item;
	cipher_item_t want;

	int chars_queued    = 0;
	int chars_sent      = 0;
	int results_checked = 0;
	int key_settings    = 0;
	int errors          = 0;
	int idle_cycles     = 0;
	int burst_left      = 0;
	int gap_left        = 0;
	int run_left        = 0;
	int stall_left      = 0;
	bit tx_steady       = 1'b0;
	bit rx_steady       = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	function automatic sym_t sym_of_char(char_t c);
		if (c >= CHAR_A && c <= CHAR_Z) return sym_t'(c - CHAR_A);
		if (c >= CHAR_0 && c <= CHAR_9) return sym_t'(c - CHAR_0 + NUM_LETTERS);
		return sym_t'(SYM_SPACE);
	endfunction

	function automatic char_t char_of_sym(int s);
		if (s < NUM_LETTERS) return char_t'(CHAR_A + s);
		if (s < SYM_SPACE) return char_t'(CHAR_0 + s - NUM_LETTERS);
		return char_t'(CHAR_SP);
	endfunction

	task automatic emit_cipher_block(int n);
		int acc;
		for (int i = 0; i < n; i++) begin
			acc = 0;
			for (int j = 0; j < n; j++) begin
				acc += int'(key_rows[i][SYM_W*j +: SYM_W]) * int'(sym_buf[j]);
			end
			cipher_expected.insert(cipher_expected.size(),
				cipher_item_t'{char_of_sym(acc % MOD_SYM), i == n - 1});
		end
		fill = 0;
	endtask

	// A block size of zero behaves as one. A flagged end pads a partial block
	// with spaces; a block that the flagged item completes is emitted once.
	task automatic encode_char(char_t c, logic msg_end);
		int n;
		n = (size_reg == '0) ? 1 : int'(size_reg);
		if (fill < MAX_BLOCK) sym_buf[fill] = sym_of_char(c);
		if (fill < MAX_BLOCK) fill++;
		if (fill >= n) begin
			emit_cipher_block(n);
		end else if (msg_end && fill > 0) begin
			for (int p = fill; p < n; p++) sym_buf[p] = sym_t'(SYM_SPACE);
			emit_cipher_block(n);
		end
	endtask

	task automatic apb_write(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(int'(idx) << REG_IDX_LSB);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_BLOCK_SIZE) size_reg = value[CNT_W-1:0];
		else key_rows[int'(idx) - 1] = value[KEY_W-1:0];
	endtask

	task automatic queue_char(char_t c, logic last, logic drain = 1'b0);
		plain_queue.insert(plain_queue.size(), plain_item_t'{c, last, drain});
		chars_queued++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (chars_sent != chars_queued || cipher_expected.size() != 0);
		// A partial block may still sit in the buffer; let the pipeline settle.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic char_t pick_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return char_t'(CHAR_A + $urandom_range(0, 25));
			5, 6:          return char_t'(CHAR_0 + $urandom_range(0, 9));
			7:             return char_t'(CHAR_SP);
			8:             return char_t'("a" + $urandom_range(0, 25));
			default:       return char_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic run_random_phase(int phase);
		int                    left;
		int                    len;
		logic [APB_DATA_W-1:0] value;
		value = {$urandom, $urandom};
		case (phase)
			0:       value[CNT_W-1:0] = 3'd1;
			1:       value[CNT_W-1:0] = 3'd7;
			2:       value[CNT_W-1:0] = 3'd4;
			default: value[CNT_W-1:0] = 3'($urandom_range(0, 7));
		endcase
		apb_write(REG_BLOCK_SIZE, value);
		for (int r = 0; r < MAX_BLOCK; r++) begin
			case ($urandom_range(0, 5))
				0:       value = '0;
				1:       value = '1;
				default: value = {$urandom, $urandom};
			endcase
			apb_write(reg_idx_t'(int'(REG_KEY_ROW_0) + r), value);
		end
		key_settings++;
		tx_steady = (phase == 2) || ($urandom_range(0, 3) == 0);
		rx_steady = (phase == 2) || ($urandom_range(0, 3) == 0);
		left = PHASE_ITEMS;
		while (left > 0) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
			if (len > left) len = left;
			// Most messages close with an end flag; the rest run into the next one.
			for (int i = 0; i < len; i++) begin
				queue_char(pick_char(), (i == len - 1) && ($urandom_range(0, 9) != 0),
					$urandom_range(0, 39) == 0);
			end
			left -= len;
		end
		wait_idle();
	endtask

	// Plaintext driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plain_if.valid       <= 1'b0;
			plain_if.plain_char  <= '0;
			plain_if.message_end <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (plain_if.valid && plain_if.ready) begin
				encode_char(plain_if.plain_char, plain_if.message_end);
				chars_sent++;
			end
			if (!plain_if.valid || plain_if.ready) begin
				if (gap_left > 0 && !tx_steady) begin
					gap_left--;
					plain_if.valid <= 1'b0;
				end else if (plain_queue.size() > 0 &&
						!(plain_queue[0].drain && cipher_expected.size() != 0)) begin
					next_item = plain_queue.pop_front();
					plain_if.valid       <= 1'b1;
					plain_if.plain_char  <= next_item.ch;
					plain_if.message_end <= next_item.last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
							: $urandom_range(0, 3);
					end else begin
						burst_left--;
					end
				end else begin
					plain_if.valid <= 1'b0;
				end
			end
		end
	end

	// Ciphertext monitor with its own run/stall pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_if.ready <= 1'b0;
			run_left   = 0;
			stall_left = 0;
		end else begin
			if (cipher_if.valid && cipher_if.ready) begin
				results_checked++;
				if (cipher_expected.size() == 0) begin
					$error("cipher item %h with block_last %b arrived with none expected",
						cipher_if.cipher_char, cipher_if.block_last);
					errors++;
				end else begin
					want = cipher_expected.pop_front();
					if (cipher_if.cipher_char !== want.ch) begin
						$error("cipher_char: expected %h, got %h", want.ch, cipher_if.cipher_char);
						errors++;
					end
					if (cipher_if.block_last !== want.last) begin
						$error("block_last: expected %b, got %b", want.last, cipher_if.block_last);
						errors++;
					end
				end
			end
			if (rx_steady) begin
				cipher_if.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				cipher_if.ready <= 1'b0;
			end else if (run_left > 0) begin
				run_left--;
				cipher_if.ready <= 1'b1;
			end else begin
				run_left   = $urandom_range(0, 10);
				stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 25)
					: $urandom_range(1, 3);
				cipher_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((plain_if.valid && plain_if.ready) || (cipher_if.valid && cipher_if.ready) ||
					(psel && penable)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$error("no handshake for %0d cycles, %0d cipher items still expected",
					idle_cycles, cipher_expected.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		plain_if.valid       = 1'b0;
		plain_if.plain_char  = '0;
		plain_if.message_end = 1'b0;
		cipher_if.ready      = 1'b0;
		size_reg             = BLOCK_SIZE_RST;
		fill                 = 0;
		foreach (key_rows[r]) key_rows[r] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// The reset key is all zero, so every symbol encrypts to 'A'.
		queue_char("A", 1'b0);
		queue_char("Z", 1'b0);
		queue_char("9", 1'b1);
		wait_idle();

		// Extreme key entries, bytes outside the alphabet, and an end flag that
		// completes a block as well as one that closes a partial block.
		apb_write(REG_BLOCK_SIZE, 64'd3);
		apb_write(REG_KEY_ROW_0, '1);
		apb_write(REG_KEY_ROW_1, 64'd1 << SYM_W);
		apb_write(REG_KEY_ROW_2, 64'h24924);
		key_settings++;
		queue_char(8'h00, 1'b0);
		queue_char(8'hFF, 1'b0);
		queue_char("0", 1'b1);
		queue_char("a", 1'b0);
		queue_char("9", 1'b1);
		wait_idle();

		apb_write(REG_BLOCK_SIZE, 64'd7);
		apb_write(REG_KEY_ROW_3, '1);
		apb_write(REG_KEY_ROW_4, {$urandom, $urandom});
		apb_write(REG_KEY_ROW_5, '0);
		apb_write(REG_KEY_ROW_6, {$urandom, $urandom});
		key_settings++;
		queue_char("Z", 1'b0);
		queue_char("0", 1'b0);
		queue_char(" ", 1'b0);
		queue_char(8'h7F, 1'b0);
		queue_char(8'h80, 1'b0);
		queue_char("9", 1'b0);
		queue_char("A", 1'b1);
		queue_char("Q", 1'b1);
		wait_idle();

		apb_write(REG_BLOCK_SIZE, 64'd0);
		queue_char("M", 1'b0);
		queue_char(" ", 1'b1);
		wait_idle();

		// Size lowered with three symbols held, then raised with one held.
		apb_write(REG_BLOCK_SIZE, 64'd5);
		queue_char("H", 1'b0);
		queue_char("I", 1'b0);
		queue_char("L", 1'b0);
		wait_idle();
		apb_write(REG_BLOCK_SIZE, 64'd2);
		queue_char("Q", 1'b0);
		queue_char("R", 1'b1);
		queue_char("K", 1'b0);
		wait_idle();
		apb_write(REG_BLOCK_SIZE, 64'd6);
		queue_char("P", 1'b1);
		wait_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) run_random_phase(phase);

		$display("Encrypted %0d plaintext items into %0d checked ciphertext items under %0d keys,",
			chars_sent, results_checked, key_settings);
		$display("covering block sizes 0 to 7, size changes mid-block and padded message ends.");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
